// ===== sv/mtds_pkg.sv =====
// shared types, constants and helpers for the multi-timer due scanner
`timescale 1ns / 1ps
`default_nettype none
package mtds_pkg;

  localparam int SLOTS      = 8;
  localparam int MAX_PASSES = 8;

  localparam int T_W    = 48;
  localparam int SLOT_W = 3;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PASS_W = $clog2(MAX_PASSES + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_RESET  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_FIRE      = 2'd0,
    KIND_NOTICE    = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_NOT_FOUND = 2'd3
  } kind_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [SLOT_W-1:0]   timer_slot;
    logic [T_W-1:0]      time_value;
    logic [T_W-1:0]      offset_or_new_time;
    logic [T_W-1:0]      period;
  } in_item_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   event_slot;
    logic [T_W-1:0]      fire_time;
    logic                wait_valid;
    logic [T_W-1:0]      wait_time;
    logic                last;
  } out_item_t;

  // one timer slot as it travels round the ring
  typedef struct packed {
    logic                active;
    logic [T_W-1:0]      due;
    logic [T_W-1:0]      period;
  } slot_entry_t;

  // controller to ring: rotate enable and the entry written back at the tail
  typedef struct packed {
    logic                shift;
    slot_entry_t         tail_in;
  } ring_ctl_t;

  function automatic logic [T_W-1:0] sat_add(input logic [T_W-1:0] a,
                                             input logic [T_W-1:0] b);
    logic [T_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[T_W] ? {T_W{1'b1}} : s[T_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/mtds_cell.sv =====
// one ring cell: holds a timer slot and passes it on when the ring rotates
`timescale 1ns / 1ps
`default_nettype none
module mtds_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 shift,
  input  wire mtds_pkg::slot_entry_t d,
  output mtds_pkg::slot_entry_t     q
);
  import mtds_pkg::*;

  logic           active_r;
  logic [T_W-1:0] due_r;
  logic [T_W-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (shift) begin
      active_r <= d.active;
    end
  end

  // timing payload needs no reset, it is only read while active
  always_ff @(posedge clk) begin
    if (shift) begin
      due_r    <= d.due;
      period_r <= d.period;
    end
  end

  assign q = '{active: active_r, due: due_r, period: period_r};

endmodule
`default_nettype wire

// ===== sv/mtds_ctrl.sv =====
// sequencer and head unit: works on the slot at the head of the ring, drives results
`timescale 1ns / 1ps
`default_nettype none
module mtds_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire mtds_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output mtds_pkg::out_item_t        out_data,
  input  wire mtds_pkg::slot_entry_t head,
  output mtds_pkg::ring_ctl_t        ring
);
  import mtds_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [PASS_W-1:0]  pass_r, pass_nxt;
  logic               again_r, again_nxt;
  logic               have_min_r, have_min_nxt;
  logic [T_W-1:0]     min_due_r, min_due_nxt;
  logic               fwd_r, fwd_nxt;
  logic [T_W-1:0]     diff_r, diff_nxt;
  logic               found_r, found_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               out_free;
  logic               due_le;
  logic               hit;
  logic               last_step;
  logic               per_nz;
  logic [T_W-1:0]     add_due;
  logic [T_W-1:0]     adv_due;
  logic [T_W-1:0]     fwd_due;
  logic [T_W-1:0]     back_due;
  logic               fire;
  logic               need_emit;
  logic               again_cur;
  logic [PASS_W-1:0]  pass_inc;
  out_item_t          emit_item;
  out_item_t          fin_item;
  logic               limit;

  assign out_free  = !out_valid_r || out_ready;
  assign due_le    = head.due <= cmd_r.time_value;
  assign hit       = SLOT_W'(step_r) == cmd_r.timer_slot;
  assign last_step = step_r == IDX_W'(SLOTS - 1);
  assign per_nz    = head.period != '0;
  assign add_due   = sat_add(cmd_r.time_value, cmd_r.offset_or_new_time);
  assign adv_due   = sat_add(head.due, head.period);
  assign fwd_due   = sat_add(head.due, diff_r);
  assign back_due  = (head.due > diff_r) ? head.due - diff_r : '0;
  assign pass_inc  = pass_r + 1'b1;
  assign limit     = pass_r == PASS_W'(MAX_PASSES);

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // final beat of the item
  always_comb begin
    fin_item            = '0;
    fin_item.last       = 1'b1;
    fin_item.event_slot = '0;
    case (cmd_r.opcode)
      OP_ADD: begin
        fin_item.event_slot = cmd_r.timer_slot;
        fin_item.kind = ({1'b0, cmd_r.timer_slot} < (SLOT_W + 1)'(SLOTS)) ?
                        KIND_DONE : KIND_NOT_FOUND;
      end
      OP_REMOVE: begin
        fin_item.event_slot = cmd_r.timer_slot;
        fin_item.kind       = found_r ? KIND_DONE : KIND_NOT_FOUND;
      end
      OP_UPDATE: begin
        fin_item.wait_valid = limit || have_min_r;
        fin_item.wait_time  = (!limit && have_min_r) ?
                              min_due_r - cmd_r.time_value : '0;
        if (pend_r) begin
          fin_item.kind       = KIND_FIRE;
          fin_item.event_slot = SLOT_W'(pend_slot_r);
          fin_item.fire_time  = cmd_r.time_value;
        end else begin
          fin_item.kind = KIND_DONE;
        end
      end
      default: begin
        fin_item.kind = KIND_DONE;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    step_nxt      = step_r;
    pass_nxt      = pass_r;
    again_nxt     = again_r;
    have_min_nxt  = have_min_r;
    min_due_nxt   = min_due_r;
    fwd_nxt       = fwd_r;
    diff_nxt      = diff_r;
    found_nxt     = found_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ring.shift    = 1'b0;
    ring.tail_in  = head;
    fire          = 1'b0;
    need_emit     = 1'b0;
    emit_item     = '0;

    // head unit: new value of the slot at the head and any beat it raises
    case (cmd_r.opcode)
      OP_ADD: begin
        if (hit) begin
          ring.tail_in = '{active: 1'b1, due: add_due, period: cmd_r.period};
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          ring.tail_in.active = 1'b0;
        end
      end
      OP_UPDATE: begin
        if (head.active && due_le) begin
          fire = 1'b1;
          // the held fire goes out only once a later one proves it is not last
          need_emit            = pend_r;
          emit_item.kind       = KIND_FIRE;
          emit_item.event_slot = SLOT_W'(pend_slot_r);
          emit_item.fire_time  = cmd_r.time_value;
          if (per_nz) begin
            ring.tail_in.due = adv_due;
          end else begin
            ring.tail_in.active = 1'b0;
          end
        end
      end
      default: begin
        if (head.active) begin
          if (fwd_r) begin
            ring.tail_in.due = fwd_due;
          end else begin
            need_emit            = 1'b1;
            emit_item.kind       = KIND_NOTICE;
            emit_item.event_slot = SLOT_W'(step_r);
            ring.tail_in.due     = back_due;
          end
        end
      end
    endcase

    again_cur = again_r || (fire && per_nz);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_data;
          step_nxt     = '0;
          pass_nxt     = '0;
          again_nxt    = 1'b0;
          have_min_nxt = 1'b0;
          found_nxt    = 1'b0;
          pend_nxt     = 1'b0;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        fwd_nxt   = cmd_r.time_value < cmd_r.offset_or_new_time;
        diff_nxt  = fwd_nxt ? cmd_r.offset_or_new_time - cmd_r.time_value :
                              cmd_r.time_value - cmd_r.offset_or_new_time;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!(need_emit && !out_free)) begin
          ring.shift = 1'b1;
          if (need_emit) begin
            out_valid_nxt = 1'b1;
            out_nxt       = emit_item;
          end
          if (cmd_r.opcode == OP_REMOVE && hit) begin
            found_nxt = head.active;
          end
          if (cmd_r.opcode == OP_UPDATE && head.active) begin
            if (due_le) begin
              pend_nxt      = 1'b1;
              pend_slot_nxt = step_r;
            end else if (!have_min_r || head.due < min_due_r) begin
              have_min_nxt = 1'b1;
              min_due_nxt  = head.due;
            end
          end
          again_nxt = again_cur;
          step_nxt  = step_r + 1'b1;
          if (last_step) begin
            step_nxt  = '0;
            pass_nxt  = pass_inc;
            again_nxt = 1'b0;
            if (!(cmd_r.opcode == OP_UPDATE && again_cur &&
                  pass_inc < PASS_W'(MAX_PASSES))) begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = fin_item;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      again_r     <= 1'b0;
      have_min_r  <= 1'b0;
      found_r     <= 1'b0;
      step_r      <= '0;
      pass_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      again_r     <= again_nxt;
      have_min_r  <= have_min_nxt;
      found_r     <= found_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
    end
    cmd_r       <= cmd_nxt;
    min_due_r   <= min_due_nxt;
    fwd_r       <= fwd_nxt;
    diff_r      <= diff_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_r       <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/multi_timer_due_scanner_unit.sv =====
// top level of the multi-timer due scanner: ring of slot cells and its sequencer
`timescale 1ns / 1ps
`default_nettype none
// The timer slots live in a ring of SLOTS cells. Each pass of a command rotates
// the ring once round, one slot per cycle when not stalled, past a single head
// unit that reads the slot at the head, works out its new timing and writes it
// back at the tail, so the ring is back in slot order when the command ends.
// A command is accepted, prepares the time-reset difference, scans in one pass
// for add, remove and time reset or in 1 to MAX_PASSES passes for a time
// update, and ends with the closing beat. A time update holds back each fire
// beat until the next fire or the end of the scan, so that the last fire can
// carry the wait time and the last flag; fires come out in pass order, then
// slot order. Any cycle in which a beat must go out while the result register
// is still full stalls the ring for that cycle. A new command can be taken
// while the previous closing beat still waits in the result register.
module multi_timer_due_scanner_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mtds_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mtds_pkg::out_item_t     out_data
);
  import mtds_pkg::*;

  // cell outputs, cell 0 is the head of the ring
  slot_entry_t cell_q [SLOTS];
  ring_ctl_t   ring;

  mtds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .head      (cell_q[0]),
    .ring      (ring)
  );

  // each cell takes its upper neighbour; the tail takes the head unit's result
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    slot_entry_t cell_d;
    if (k == SLOTS - 1) begin : g_tail
      assign cell_d = ring.tail_in;
    end else begin : g_body
      assign cell_d = cell_q[k+1];
    end
    mtds_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ring.shift),
      .d     (cell_d),
      .q     (cell_q[k])
    );
  end

endmodule
`default_nettype wire

// ===== sv/mtds_checker.sv =====
// port-level checks for the multi-timer due scanner and their bind
`timescale 1ns / 1ps
`default_nettype none
module mtds_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mtds_pkg::out_item_t out_data
);
  import mtds_pkg::*;

  // nothing left in the result register after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // one command at a time: the port closes right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in progress");

  // a waiting result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed before it was taken");

  // a wait is only reported on the closing beat
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wait_valid |-> out_data.last)
    else $error("wait time on a beat that is not last");

  // only fire beats carry a time
  a_fire_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_FIRE |-> out_data.fire_time == '0)
    else $error("fire time on a beat that is not a fire");

endmodule

bind multi_timer_due_scanner_unit mtds_checker u_mtds_checker (.*);
`default_nettype wire

// ===== sim/mtds_event_checker.sv =====
// scoreboard for the timer scanner: mirrors the slot bank and checks every result beat
`timescale 1ns / 1ps
module mtds_event_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire mtds_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire mtds_pkg::out_item_t out_data,
  output int                       fail_count,
  output int                       outstanding
);
  import mtds_pkg::*;

  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

  // mirror of the slot bank
  logic [SLOTS-1:0] timer_armed;
  logic [T_W-1:0]   timer_due    [SLOTS];
  logic [T_W-1:0]   timer_period [SLOTS];

  out_item_t expected_events [$];
  int        fails = 0;

  function automatic logic [T_W-1:0] clip_sum(input logic [T_W-1:0] a,
                                              input logic [T_W-1:0] b);
    return (b > T_MAX - a) ? T_MAX : a + b;
  endfunction

  task automatic queue_expected(input out_item_t b);
    expected_events = {expected_events, b};
  endtask

  task automatic predict_timer_events(input in_item_t cmd);
    out_item_t      beat;
    out_item_t      held;
    logic           have_held;
    logic           again;
    logic           have_min;
    logic           fwd;
    logic [T_W-1:0] min_wait;
    logic [T_W-1:0] gap;
    logic [T_W-1:0] shift;
    int             passes;
    int             s;
    beat = '0;
    held = '0;
    case (cmd.opcode)
      OP_ADD: begin
        beat.event_slot = cmd.timer_slot;
        beat.last       = 1'b1;
        if (int'(cmd.timer_slot) < SLOTS) begin
          timer_armed[cmd.timer_slot]  = 1'b1;
          timer_due[cmd.timer_slot]    = clip_sum(cmd.time_value, cmd.offset_or_new_time);
          timer_period[cmd.timer_slot] = cmd.period;
          beat.kind = KIND_DONE;
        end else begin
          beat.kind = KIND_NOT_FOUND;
        end
        queue_expected(beat);
      end
      OP_REMOVE: begin
        beat.event_slot = cmd.timer_slot;
        beat.last       = 1'b1;
        if (int'(cmd.timer_slot) < SLOTS && timer_armed[cmd.timer_slot]) begin
          timer_armed[cmd.timer_slot] = 1'b0;
          beat.kind = KIND_DONE;
        end else begin
          beat.kind = KIND_NOT_FOUND;
        end
        queue_expected(beat);
      end
      OP_UPDATE: begin
        // each fire is held back so the final one can take the wait and last flag
        again     = 1'b1;
        have_min  = 1'b0;
        have_held = 1'b0;
        min_wait  = '0;
        passes    = 0;
        while (again && passes < MAX_PASSES) begin
          again = 1'b0;
          for (s = 0; s < SLOTS; s++) begin
            if (timer_armed[s]) begin
              if (timer_due[s] > cmd.time_value) begin
                gap = timer_due[s] - cmd.time_value;
                if (!have_min || gap < min_wait) begin
                  min_wait = gap;
                  have_min = 1'b1;
                end
              end else begin
                if (have_held) queue_expected(held);
                held            = '0;
                held.kind       = KIND_FIRE;
                held.event_slot = SLOT_W'(s);
                held.fire_time  = cmd.time_value;
                have_held       = 1'b1;
                if (timer_period[s] == '0) begin
                  timer_armed[s] = 1'b0;
                end else begin
                  timer_due[s] = clip_sum(timer_due[s], timer_period[s]);
                  again        = 1'b1;
                end
              end
            end
          end
          passes++;
        end
        // pass limit reached: wait forced to zero
        if (passes >= MAX_PASSES) begin
          have_min = 1'b1;
          min_wait = '0;
        end
        if (!have_held) begin
          held      = '0;
          held.kind = KIND_DONE;
        end
        held.wait_valid = have_min;
        held.wait_time  = have_min ? min_wait : '0;
        held.last       = 1'b1;
        queue_expected(held);
      end
      default: begin
        fwd   = cmd.time_value < cmd.offset_or_new_time;
        shift = fwd ? cmd.offset_or_new_time - cmd.time_value
                    : cmd.time_value - cmd.offset_or_new_time;
        for (s = 0; s < SLOTS; s++) begin
          if (timer_armed[s]) begin
            if (fwd) begin
              timer_due[s] = clip_sum(timer_due[s], shift);
            end else begin
              beat            = '0;
              beat.kind       = KIND_NOTICE;
              beat.event_slot = SLOT_W'(s);
              queue_expected(beat);
              timer_due[s] = (timer_due[s] > shift) ? timer_due[s] - shift : '0;
            end
          end
        end
        beat      = '0;
        beat.kind = KIND_DONE;
        beat.last = 1'b1;
        queue_expected(beat);
      end
    endcase
  endtask

  task automatic check_event(input out_item_t got);
    out_item_t exp;
    if (expected_events.size() == 0) begin
      $error("unexpected result beat: kind %0d slot %0d", got.kind, got.event_slot);
      fails++;
    end else begin
      exp = expected_events.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        fails++;
      end
      if (got.event_slot !== exp.event_slot) begin
        $error("event_slot: expected %0d, got %0d", exp.event_slot, got.event_slot);
        fails++;
      end
      if (got.fire_time !== exp.fire_time) begin
        $error("fire_time: expected %0h, got %0h", exp.fire_time, got.fire_time);
        fails++;
      end
      if (got.wait_valid !== exp.wait_valid) begin
        $error("wait_valid: expected %0d, got %0d", exp.wait_valid, got.wait_valid);
        fails++;
      end
      if (got.wait_time !== exp.wait_time) begin
        $error("wait_time: expected %0h, got %0h", exp.wait_time, got.wait_time);
        fails++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        fails++;
      end
    end
  endtask

  // result beats first: a beat can never belong to a command taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      timer_armed = '0;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) check_event(out_data);
      if (in_valid && in_ready) predict_timer_events(in_data);
    end
    fail_count  <= fails;
    outstanding <= expected_events.size();
  end

endmodule

// ===== sim/tb_multi_timer_due_scanner_unit.sv =====
// testbench top for the timer scanner: clock, reset, command stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_multi_timer_due_scanner_unit;
  import mtds_pkg::*;

  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

  // receiver behaviour modes
  localparam int RX_FREE   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;

  // long hold-off on the result side, in cycles
  localparam int HOLD_CYCLES = 400;

  // longer than the worst update, so this covers any tail
  localparam int DRAIN_CYCLES = 100;

  localparam int RANDOM_ITEMS = 160;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic hold_req = 1'b0;
  int   fail_count;
  int   outstanding;
  int   burst_left = 4;

  // receiver process state
  int   rx_mode      = RX_FREE;
  int   rx_mode_left = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  multi_timer_due_scanner_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mtds_event_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic in_item_t make_cmd(input opcode_t op, input int slot,
                                        input logic [T_W-1:0] tv,
                                        input logic [T_W-1:0] ov,
                                        input logic [T_W-1:0] per);
    in_item_t cmd;
    cmd.opcode             = op;
    cmd.timer_slot         = SLOT_W'(slot);
    cmd.time_value         = tv;
    cmd.offset_or_new_time = ov;
    cmd.period             = per;
    return cmd;
  endfunction

  function automatic logic [T_W-1:0] rand_t48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[T_W-1:0];
  endfunction

  // present one command beat and hold it until taken; the sender works in
  // bursts, idling for a random gap once a burst runs out
  task automatic offer_beat(input in_item_t cmd);
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      // now and then a long burst gives a stretch with no sender gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
  endtask

  // result side: random stall modes, switched at random, plus
  // one long hold-off so the block backs up and drops in_ready
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left <= 0) begin
        rx_mode      = $urandom_range(RX_FREE, RX_SPARSE);
        rx_mode_left = $urandom_range(10, 60);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_item_t       cmd;
    logic [T_W-1:0] wall_time;
    logic [T_W-1:0] reset_to;
    logic [T_W-1:0] step;
    int             pick;
    int             n;
    int             s;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    // update on an empty bank: done, no wait reported
    offer_beat(make_cmd(OP_UPDATE, 0, '0, '0, '0));
    // remove of a slot never armed
    offer_beat(make_cmd(OP_REMOVE, 3, '0, '0, '0));
    // periodic slot firing in seven passes, eighth pass idle: pass limit still hits
    offer_beat(make_cmd(OP_ADD, 0, '0, '0, 48'd10));
    offer_beat(make_cmd(OP_UPDATE, 0, 48'd65, '0, '0));
    // add whose due time saturates
    offer_beat(make_cmd(OP_ADD, 7, T_MAX, T_MAX, '0));
    // one-shot and a periodic slot with the widest period
    offer_beat(make_cmd(OP_ADD, 1, 48'd100, 48'd5, '0));
    offer_beat(make_cmd(OP_ADD, 2, 48'd100, '0, T_MAX));
    offer_beat(make_cmd(OP_UPDATE, 0, 48'd105, '0, '0));
    // forward time reset saturating, equal reset, backward reset clamping at zero
    offer_beat(make_cmd(OP_RESET, 0, '0, T_MAX, '0));
    offer_beat(make_cmd(OP_RESET, 0, 48'd500, 48'd500, '0));
    offer_beat(make_cmd(OP_RESET, 0, T_MAX, '0, '0));
    // every armed slot now due at once
    offer_beat(make_cmd(OP_UPDATE, 0, '0, '0, '0));
    // remove of an armed slot
    offer_beat(make_cmd(OP_REMOVE, 0, '0, '0, '0));
    // periodic advance saturating at the top of the time range
    offer_beat(make_cmd(OP_ADD, 4, T_MAX - 48'd10, '0, 48'd100));
    offer_beat(make_cmd(OP_UPDATE, 0, T_MAX - 48'd5, '0, '0));
    // all slots armed with period 1, overwriting live ones: the largest fire burst
    for (s = 0; s < SLOTS; s++) offer_beat(make_cmd(OP_ADD, s, 48'd1000, '0, 48'd1));
    offer_beat(make_cmd(OP_UPDATE, 0, 48'd2000, '0, '0));

    // random part: mostly a coherent timeline, with some noise
    hold_req  <= 1'b1;
    wall_time = 48'd3000;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        cmd = make_cmd(OP_ADD, $urandom_range(0, SLOTS - 1), wall_time,
                       T_W'($urandom_range(0, 200)),
                       ($urandom_range(0, 4) < 2) ? '0 : T_W'($urandom_range(1, 100)));
      end else if (pick < 50) begin
        cmd = make_cmd(OP_REMOVE, $urandom_range(0, SLOTS - 1), '0, '0, '0);
      end else if (pick < 85) begin
        wall_time = wall_time + T_W'($urandom_range(0, 150));
        cmd = make_cmd(OP_UPDATE, 0, wall_time, '0, '0);
      end else if (pick < 90) begin
        step = T_W'($urandom_range(0, 300));
        case ($urandom_range(0, 2))
          0:       reset_to = wall_time;
          1:       reset_to = wall_time + step;
          default: reset_to = (wall_time > step) ? wall_time - step : '0;
        endcase
        cmd = make_cmd(OP_RESET, 0, wall_time, reset_to, '0);
        wall_time = reset_to;
      end else begin
        cmd = make_cmd(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                       rand_t48(), rand_t48(), rand_t48());
      end
      offer_beat(cmd);
    end
    in_valid <= 1'b0;

    // wait for the checker's registered count to include the last command, then
    // drain and let any late beat show up
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mtds_pkg.sv
sv/mtds_cell.sv
sv/mtds_ctrl.sv
sv/multi_timer_due_scanner_unit.sv
sv/mtds_checker.sv
sim/mtds_event_checker.sv
sim/tb_multi_timer_due_scanner_unit.sv
